### hdl/stv_pkg.sv
// shared constants, tables and types of the shell tetrahedron vertex indexer
`default_nettype none

package stv_pkg;

   localparam int DEF_MAX_TANGENTIAL = 257;
   localparam int DEF_MAX_RADIAL     = 256;

   localparam int IDX_W     = 32;
   localparam int VERTEX_W  = 28;
   localparam int CSR_W     = 9;
   localparam int CSR_IDX_W = 2;
   localparam int DIAM_W    = 4;
   localparam int TET_W     = 3;
   localparam int CORNER_W  = 3;

   localparam int NUM_HEMI_DIAMONDS = 5;
   localparam int TETS_PER_CELL     = 6;
   localparam int DIAMONDS          = 10;
   localparam int CELLS_PER_SHELL   = TETS_PER_CELL * DIAMONDS;

   localparam logic [CSR_W-1:0] RESET_TANGENTIAL = 9'd17;
   localparam logic [CSR_W-1:0] RESET_RADIAL     = 9'd2;

   localparam int SETTLE_W = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TANGENTIAL = 2'd0,
      CSR_RADIAL     = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic oor;
   } ctrl_type;

   // corner offsets packed as {first, second, layer}
   localparam logic [2:0] CORNER_OFF [0:7] = '{
      3'b001, 3'b101, 3'b111, 3'b011, 3'b000, 3'b100, 3'b110, 3'b010
   };

   localparam logic [CORNER_W-1:0] NORTH_PICK [0:5][0:3] = '{
      '{3'd0, 3'd1, 3'd3, 3'd7}, '{3'd4, 3'd7, 3'd5, 3'd0}, '{3'd0, 3'd5, 3'd1, 3'd7},
      '{3'd1, 3'd2, 3'd3, 3'd6}, '{3'd5, 3'd7, 3'd6, 3'd1}, '{3'd3, 3'd6, 3'd7, 3'd1}
   };

   localparam logic [CORNER_W-1:0] SOUTH_PICK [0:5][0:3] = '{
      '{3'd4, 3'd7, 3'd5, 3'd1}, '{3'd0, 3'd1, 3'd3, 3'd4}, '{3'd4, 3'd3, 3'd7, 3'd1},
      '{3'd7, 3'd6, 3'd5, 3'd2}, '{3'd3, 3'd1, 3'd2, 3'd7}, '{3'd5, 3'd2, 3'd1, 3'd7}
   };

endpackage

`default_nettype wire

### hdl/stv_split.sv
// restoring divider pipeline that splits the element index into layer, diamond and cell
`default_nettype none

module stv_split #(
   parameter int MAX_TANGENTIAL = stv_pkg::DEF_MAX_TANGENTIAL,
   parameter int MAX_RADIAL     = stv_pkg::DEF_MAX_RADIAL,
   localparam int MW   = $clog2(MAX_TANGENTIAL),
   localparam int QB   = $clog2(MAX_TANGENTIAL - 1),
   localparam int QR   = $clog2(MAX_RADIAL),
   localparam int RW   = $clog2(MAX_RADIAL + 1),
   localparam int SQW  = 2 * MW,
   localparam int U60W = SQW + 6,
   localparam int S6W  = SQW + 3,
   localparam int M6W  = MW + 3,
   localparam int CNTW = U60W + RW
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [stv_pkg::IDX_W-1:0]      element_index,
   input  logic [CNTW-1:0]                count,
   input  logic [U60W-1:0]                unit_shell,
   input  logic [S6W-1:0]                 unit_diamond,
   input  logic [M6W-1:0]                 unit_row,
   output stv_pkg::ctrl_type              ctrl_out,
   output logic [QR-1:0]                  layer,
   output logic [stv_pkg::DIAM_W-1:0]     diamond,
   output logic [QB-1:0]                  coord_b,
   output logic [QB-1:0]                  coord_a,
   output logic [stv_pkg::TET_W-1:0]      tet
);
   import stv_pkg::*;

   localparam int S    = QR + DIAM_W + 2 * QB;
   localparam int CW   = (U60W + QR > IDX_W) ? U60W + QR : IDX_W;
   localparam int CMPW = (CNTW > IDX_W) ? CNTW : IDX_W;

   typedef struct packed {
      ctrl_type          ctrl;
      logic [IDX_W-1:0]  rem;
      logic [QR-1:0]     ir;
      logic [DIAM_W-1:0] dq;
      logic [QB-1:0]     bq;
      logic [QB-1:0]     aq;
   } stage_type;

   stage_type stage_ff [0:S];
   stage_type stage_in [0:S];

   always_comb begin
      stage_in[0].ctrl.valid = accept;
      stage_in[0].ctrl.oor   = CMPW'(element_index) >= CMPW'(count);
      stage_in[0].rem        = element_index;
      stage_in[0].ir         = '0;
      stage_in[0].dq         = '0;
      stage_in[0].bq         = '0;
      stage_in[0].aq         = '0;
   end

   for (genvar j = 1; j <= S; j++) begin : g_step
      // quotient bits come msb first: layer, diamond, row, column
      localparam int KIND = (j <= QR) ? 0 : (j <= QR + DIAM_W) ? 1 :
                            (j <= QR + DIAM_W + QB) ? 2 : 3;
      localparam int SH   = (KIND == 0) ? QR - j :
                            (KIND == 1) ? QR + DIAM_W - j :
                            (KIND == 2) ? QR + DIAM_W + QB - j : S - j;
      logic [CW-1:0] div_w;
      logic          ge_w;

      always_comb begin
         if (KIND == 0) begin
            div_w = CW'(unit_shell) << SH;
         end else if (KIND == 1) begin
            div_w = CW'(unit_diamond) << SH;
         end else if (KIND == 2) begin
            div_w = CW'(unit_row) << SH;
         end else begin
            div_w = CW'(TETS_PER_CELL) << SH;
         end
         ge_w = CW'(stage_ff[j-1].rem) >= div_w;
         stage_in[j] = stage_ff[j-1];
         if (ge_w) begin
            stage_in[j].rem = stage_ff[j-1].rem - div_w[IDX_W-1:0];
         end
         if (KIND == 0) begin
            stage_in[j].ir = (stage_ff[j-1].ir << 1) | QR'(ge_w);
         end else if (KIND == 1) begin
            stage_in[j].dq = (stage_ff[j-1].dq << 1) | DIAM_W'(ge_w);
         end else if (KIND == 2) begin
            stage_in[j].bq = (stage_ff[j-1].bq << 1) | QB'(ge_w);
         end else begin
            stage_in[j].aq = (stage_ff[j-1].aq << 1) | QB'(ge_w);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= S; i++) begin
         if (reset) begin
            stage_ff[i].ctrl <= '0;
         end else begin
            stage_ff[i].ctrl <= stage_in[i].ctrl;
         end
         stage_ff[i].rem <= stage_in[i].rem;
         stage_ff[i].ir  <= stage_in[i].ir;
         stage_ff[i].dq  <= stage_in[i].dq;
         stage_ff[i].bq  <= stage_in[i].bq;
         stage_ff[i].aq  <= stage_in[i].aq;
      end
   end

   assign ctrl_out = stage_ff[S].ctrl;
   assign layer    = stage_ff[S].ir;
   assign diamond  = stage_ff[S].dq;
   assign coord_b  = stage_ff[S].bq;
   assign coord_a  = stage_ff[S].aq;
   assign tet      = stage_ff[S].rem[TET_W-1:0];

endmodule

`default_nettype wire

### hdl/stv_corner.sv
// corner pick, edge correction and vertex index pipeline over four lanes
`default_nettype none

module stv_corner #(
   parameter int MAX_TANGENTIAL = stv_pkg::DEF_MAX_TANGENTIAL,
   parameter int MAX_RADIAL     = stv_pkg::DEF_MAX_RADIAL,
   localparam int MW   = $clog2(MAX_TANGENTIAL),
   localparam int QB   = $clog2(MAX_TANGENTIAL - 1),
   localparam int QR   = $clog2(MAX_RADIAL),
   localparam int RW   = $clog2(MAX_RADIAL + 1),
   localparam int SQW  = 2 * MW,
   localparam int M10W = SQW + 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  stv_pkg::ctrl_type              ctrl,
   input  logic [QR-1:0]                  layer,
   input  logic [stv_pkg::DIAM_W-1:0]     diamond,
   input  logic [QB-1:0]                  coord_b,
   input  logic [QB-1:0]                  coord_a,
   input  logic [stv_pkg::TET_W-1:0]      tet,
   input  logic [MW-1:0]                  m,
   input  logic [SQW-1:0]                 m_sq,
   input  logic [M10W-1:0]                m_sq10,
   input  logic [RW-1:0]                  nrad,
   output logic                           rsp_strobe,
   output logic [stv_pkg::VERTEX_W-1:0]   rsp_vertex_a,
   output logic [stv_pkg::VERTEX_W-1:0]   rsp_vertex_b,
   output logic [stv_pkg::VERTEX_W-1:0]   rsp_vertex_c,
   output logic [stv_pkg::VERTEX_W-1:0]   rsp_vertex_d,
   output logic                           rsp_index_out_of_range
);
   import stv_pkg::*;

   localparam int VW = VERTEX_W;
   localparam int LANES = 4;

   // first stage: corner selection and edge correction
   ctrl_type          c1_ff, c1_in;
   logic [QR-1:0]     ir1_ff;
   logic              south1_ff, south_w;
   logic [VW-1:0]     base_ff, base_in;
   logic [DIAM_W-1:0] d5_w, prev_w;
   logic [TET_W-1:0]  tt_w;
   logic [CORNER_W-1:0] cid_w [LANES];
   logic [2:0]        off_w [LANES];
   logic [MW-1:0]     ka_w [LANES];
   logic [MW-1:0]     kb_w [LANES];
   logic [MW-1:0]     bn_w [LANES];
   logic              pole1_ff [LANES];
   logic              pole1_in [LANES];
   logic              o3_ff [LANES];
   logic              o3_in [LANES];
   logic [MW-1:0]     an_ff [LANES];
   logic [MW-1:0]     an_in [LANES];
   logic [MW-1:0]     bm1_ff [LANES];
   logic [MW-1:0]     bm1_in [LANES];
   logic [DIAM_W-1:0] dn_ff [LANES];
   logic [DIAM_W-1:0] dn_in [LANES];

   always_comb begin
      south_w = diamond >= DIAM_W'(NUM_HEMI_DIAMONDS);
      d5_w    = south_w ? diamond - DIAM_W'(NUM_HEMI_DIAMONDS) : diamond;
      prev_w  = (d5_w == '0) ? DIAM_W'(NUM_HEMI_DIAMONDS - 1) : d5_w - DIAM_W'(1);
      tt_w    = (tet < TET_W'(TETS_PER_CELL)) ? tet : '0;
      c1_in   = ctrl;
      base_in = VW'(VW'(layer) * VW'(m_sq10));
      for (int l = 0; l < LANES; l++) begin
         cid_w[l] = south_w ? SOUTH_PICK[tt_w][l] : NORTH_PICK[tt_w][l];
         off_w[l] = CORNER_OFF[cid_w[l]];
         // southern diamonds swap the two in-plane offsets
         ka_w[l]  = MW'(coord_a) + MW'(south_w ? off_w[l][1] : off_w[l][2]);
         kb_w[l]  = MW'(coord_b) + MW'(south_w ? off_w[l][2] : off_w[l][1]);
         o3_in[l] = off_w[l][0];
         pole1_in[l] = (ka_w[l] == '0) && (kb_w[l] == '0);
         if (kb_w[l] == '0) begin
            // upper-left edge: previous diamond, same hemisphere
            an_in[l] = '0;
            bn_w[l]  = ka_w[l];
            dn_in[l] = south_w ? prev_w + DIAM_W'(NUM_HEMI_DIAMONDS) : prev_w;
         end else if (ka_w[l] == m) begin
            // lower-left edge: adjoining diamond of the other hemisphere
            an_in[l] = m - kb_w[l];
            bn_w[l]  = m;
            dn_in[l] = south_w ? d5_w : prev_w + DIAM_W'(NUM_HEMI_DIAMONDS);
         end else begin
            an_in[l] = ka_w[l];
            bn_w[l]  = kb_w[l];
            dn_in[l] = diamond;
         end
         bm1_in[l] = bn_w[l] - MW'(1);
      end
   end

   // second stage: the two products per lane
   ctrl_type      c2_ff;
   logic [VW-1:0] dterm_ff [LANES];
   logic [VW-1:0] dterm_in [LANES];
   logic [VW-1:0] bterm_ff [LANES];
   logic [VW-1:0] bterm_in [LANES];
   logic [VW-1:0] rest_ff [LANES];
   logic [VW-1:0] rest_in [LANES];
   logic [VW-1:0] polev_ff [LANES];
   logic [VW-1:0] polev_in [LANES];
   logic          pole2_ff [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         dterm_in[l] = VW'(VW'(dn_ff[l]) * VW'(m_sq));
         bterm_in[l] = VW'(VW'(bm1_ff[l]) * VW'(m));
         rest_in[l]  = base_ff + (o3_ff[l] ? VW'(m_sq10) : '0) + VW'(an_ff[l])
                       + (VW'(nrad) << 1);
         polev_in[l] = VW'(ir1_ff) + VW'(o3_ff[l]) + (south1_ff ? VW'(nrad) : '0);
      end
   end

   // third stage: final sum into the output register
   ctrl_type      c3_ff;
   logic [VW-1:0] vtx_ff [LANES];
   logic [VW-1:0] vtx_in [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (c2_ff.oor) begin
            vtx_in[l] = '0;
         end else if (pole2_ff[l]) begin
            vtx_in[l] = polev_ff[l];
         end else begin
            vtx_in[l] = dterm_ff[l] + bterm_ff[l] + rest_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
      end else begin
         c1_ff <= c1_in;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
      end
      ir1_ff    <= layer;
      south1_ff <= south_w;
      base_ff   <= base_in;
      for (int l = 0; l < LANES; l++) begin
         pole1_ff[l] <= pole1_in[l];
         o3_ff[l]    <= o3_in[l];
         an_ff[l]    <= an_in[l];
         bm1_ff[l]   <= bm1_in[l];
         dn_ff[l]    <= dn_in[l];
         dterm_ff[l] <= dterm_in[l];
         bterm_ff[l] <= bterm_in[l];
         rest_ff[l]  <= rest_in[l];
         polev_ff[l] <= polev_in[l];
         pole2_ff[l] <= pole1_ff[l];
         vtx_ff[l]   <= vtx_in[l];
      end
   end

   assign rsp_strobe             = c3_ff.valid;
   assign rsp_index_out_of_range = c3_ff.oor;
   assign rsp_vertex_a           = vtx_ff[0];
   assign rsp_vertex_b           = vtx_ff[1];
   assign rsp_vertex_c           = vtx_ff[2];
   assign rsp_vertex_d           = vtx_ff[3];

endmodule

`default_nettype wire

### hdl/shell_tetra_cell_vertex_indexer_unit.sv
// top level of the shell tetrahedron vertex indexer: csr, derived mesh sizes and pipeline
//
// usage: a request (req_element_index) is taken at a rising edge with start high and busy low.
// the four vertex indices and the out-of-range flag appear on the rsp_ ports for exactly
// one cycle, marked by rsp_strobe; the receiver cannot hold them off and needs no handshake.
// a new request may enter every cycle while busy is low; results leave in request order.
// the pipeline has S = clog2(MAX_RADIAL) + 4 + 2 * clog2(MAX_TANGENTIAL - 1) restoring-divider
// steps (one quotient bit per stage) followed by three vertex stages.
// throughput: one request per cycle unless busy, set by the one-step-per-stage divider chain.
// csr: csr_write with csr_index 0 (tangential points) or 1 (radial layers) and csr_data;
// other indexes are dropped. the user must write only while no request is in flight, as
// the block does not enforce it. after a write, and after reset, busy stays high while
// the derived mesh sizes (m squared, shell and diamond units, element count) are recomputed.
// reset is synchronous: registers return to 17 tangential points and 2 radial layers,
// and every request in flight is dropped.
`default_nettype none

module shell_tetra_cell_vertex_indexer_unit #(
   parameter int MAX_TANGENTIAL = stv_pkg::DEF_MAX_TANGENTIAL,
   parameter int MAX_RADIAL     = stv_pkg::DEF_MAX_RADIAL
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [stv_pkg::IDX_W-1:0]      req_element_index,
   output logic                           rsp_strobe,
   output logic [stv_pkg::VERTEX_W-1:0]   rsp_vertex_a,
   output logic [stv_pkg::VERTEX_W-1:0]   rsp_vertex_b,
   output logic [stv_pkg::VERTEX_W-1:0]   rsp_vertex_c,
   output logic [stv_pkg::VERTEX_W-1:0]   rsp_vertex_d,
   output logic                           rsp_index_out_of_range,
   input  logic                           csr_write,
   input  logic [stv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stv_pkg::CSR_W-1:0]      csr_data
);
   import stv_pkg::*;

   localparam int MW   = $clog2(MAX_TANGENTIAL);
   localparam int QB   = $clog2(MAX_TANGENTIAL - 1);
   localparam int QR   = $clog2(MAX_RADIAL);
   localparam int RW   = $clog2(MAX_RADIAL + 1);
   localparam int SQW  = 2 * MW;
   localparam int U60W = SQW + 6;
   localparam int S6W  = SQW + 3;
   localparam int M6W  = MW + 3;
   localparam int M10W = SQW + 4;
   localparam int CNTW = U60W + RW;
   localparam int LAT  = QR + DIAM_W + 2 * QB + 4;

   logic [CSR_W-1:0]    csr_tan_ff, csr_tan_in;
   logic [CSR_W-1:0]    csr_rad_ff, csr_rad_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;
   logic [MW-1:0]       m_c, m_ff;
   logic [RW-1:0]       nrad_c, nrad_ff, nm1_ff;
   logic [SQW-1:0]      msq_ff;
   logic [U60W-1:0]     u60_ff;
   logic [S6W-1:0]      u6sq_ff;
   logic [M6W-1:0]      u6m_ff;
   logic [M10W-1:0]     mm10_ff;
   logic [CNTW-1:0]     count_ff;
   logic                accept;

   always_comb begin
      csr_tan_in = csr_tan_ff;
      csr_rad_in = csr_rad_ff;
      settle_in  = (settle_ff != '0) ? settle_ff - SETTLE_W'(1) : '0;
      if (csr_write) begin
         settle_in = SETTLE_CYCLES;
         unique case (csr_index)
            CSR_TANGENTIAL: csr_tan_in = csr_data;
            CSR_RADIAL:     csr_rad_in = csr_data;
            default: ;
         endcase
      end
   end

   // saturate the registers into the supported mesh range
   always_comb begin
      if (csr_tan_ff < CSR_W'(2)) begin
         m_c = MW'(1);
      end else if (csr_tan_ff > MAX_TANGENTIAL) begin
         m_c = MW'(MAX_TANGENTIAL - 1);
      end else begin
         m_c = MW'(csr_tan_ff - CSR_W'(1));
      end
      if (csr_rad_ff < CSR_W'(2)) begin
         nrad_c = RW'(2);
      end else if (csr_rad_ff > MAX_RADIAL) begin
         nrad_c = RW'(MAX_RADIAL);
      end else begin
         nrad_c = RW'(csr_rad_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_tan_ff <= RESET_TANGENTIAL;
         csr_rad_ff <= RESET_RADIAL;
         settle_ff  <= SETTLE_CYCLES;
      end else begin
         csr_tan_ff <= csr_tan_in;
         csr_rad_ff <= csr_rad_in;
         settle_ff  <= settle_in;
      end
      m_ff     <= m_c;
      nrad_ff  <= nrad_c;
      nm1_ff   <= nrad_c - RW'(1);
      msq_ff   <= SQW'(m_c) * SQW'(m_c);
      u60_ff   <= U60W'(msq_ff) * U60W'(CELLS_PER_SHELL);
      u6sq_ff  <= S6W'(msq_ff) * S6W'(TETS_PER_CELL);
      u6m_ff   <= M6W'(m_ff) * M6W'(TETS_PER_CELL);
      mm10_ff  <= M10W'(msq_ff) * M10W'(DIAMONDS);
      count_ff <= CNTW'(u60_ff) * CNTW'(nm1_ff);
   end

   assign busy   = settle_ff != '0;
   assign accept = start && !busy;

   ctrl_type            split_ctrl;
   logic [QR-1:0]       split_layer;
   logic [DIAM_W-1:0]   split_diamond;
   logic [QB-1:0]       split_b;
   logic [QB-1:0]       split_a;
   logic [TET_W-1:0]    split_tet;

   stv_split #(
      .MAX_TANGENTIAL(MAX_TANGENTIAL),
      .MAX_RADIAL(MAX_RADIAL)
   ) u_split (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .element_index(req_element_index),
      .count(count_ff),
      .unit_shell(u60_ff),
      .unit_diamond(u6sq_ff),
      .unit_row(u6m_ff),
      .ctrl_out(split_ctrl),
      .layer(split_layer),
      .diamond(split_diamond),
      .coord_b(split_b),
      .coord_a(split_a),
      .tet(split_tet)
   );

   stv_corner #(
      .MAX_TANGENTIAL(MAX_TANGENTIAL),
      .MAX_RADIAL(MAX_RADIAL)
   ) u_corner (
      .clock(clock),
      .reset(reset),
      .ctrl(split_ctrl),
      .layer(split_layer),
      .diamond(split_diamond),
      .coord_b(split_b),
      .coord_a(split_a),
      .tet(split_tet),
      .m(m_ff),
      .m_sq(msq_ff),
      .m_sq10(mm10_ff),
      .nrad(nrad_ff),
      .rsp_strobe(rsp_strobe),
      .rsp_vertex_a(rsp_vertex_a),
      .rsp_vertex_b(rsp_vertex_b),
      .rsp_vertex_c(rsp_vertex_c),
      .rsp_vertex_d(rsp_vertex_d),
      .rsp_index_out_of_range(rsp_index_out_of_range)
   );

   // derived sizes must settle before a request is taken
   a_busy_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> busy)
      else $error("busy not raised after csr write");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("response missing at pipeline latency");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_index_out_of_range) |->
         (rsp_vertex_a == '0 && rsp_vertex_b == '0 &&
          rsp_vertex_c == '0 && rsp_vertex_d == '0))
      else $error("out-of-range response carries nonzero vertices");

endmodule

`default_nettype wire
